// File: sv/str_pkg.sv
// ----------------------------------------------------------------------------
// str_pkg
// Shared types and constants of the scan telegram receiver: phase encoding,
// result kinds, register map and the configuration and result bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package str_pkg;

	// register map
	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	typedef enum logic [1:0] {
		REG_START   = 2'd0,
		REG_ADDRESS = 2'd1,
		REG_COMMAND = 2'd2,
		REG_COUNT   = 2'd3
	} reg_idx_t;

	// reset values of the registers
	localparam logic [7:0] START_RST   = 8'h02;
	localparam logic [7:0] ADDRESS_RST = 8'h80;
	localparam logic [7:0] COMMAND_RST = 8'hb0;
	localparam logic [9:0] COUNT_RST   = 10'd361;

	// receive phase
	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_CRC_LO  = 2'd2,
		PH_CRC_HI  = 2'd3
	} phase_t;

	// result kinds
	typedef enum logic [1:0] {
		KIND_RANGE   = 2'd0,
		KIND_GOOD    = 2'd1,
		KIND_CRC_ERR = 2'd2,
		KIND_BAD_LEN = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] address_byte;
		logic [7:0] command_byte;
		logic [9:0] value_count;
	} cfg_t;

	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic [12:0] range_value;
		logic [9:0]  value_index;
		logic        frame_end;
	} res_t;

endpackage

`default_nettype wire

// File: sv/str_cfg_regs.sv
// ----------------------------------------------------------------------------
// str_cfg_regs
// APB register bank: start, address and command bytes and the value count.
// ----------------------------------------------------------------------------
`default_nettype none

module str_cfg_regs
	import str_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte   <= START_RST;
			cfg_q.address_byte <= ADDRESS_RST;
			cfg_q.command_byte <= COMMAND_RST;
			cfg_q.value_count  <= COUNT_RST;
		end else if (wr_en) begin
			case (idx)
				REG_START:   cfg_q.start_byte   <= pwdata[7:0];
				REG_ADDRESS: cfg_q.address_byte <= pwdata[7:0];
				REG_COMMAND: cfg_q.command_byte <= pwdata[7:0];
				REG_COUNT:   cfg_q.value_count  <= pwdata[9:0];
				default:     cfg_q.start_byte   <= cfg_q.start_byte;
			endcase
		end
	end

	// read back
	always_comb begin
		case (idx)
			REG_START:   prdata = {24'd0, cfg_q.start_byte};
			REG_ADDRESS: prdata = {24'd0, cfg_q.address_byte};
			REG_COMMAND: prdata = {24'd0, cfg_q.command_byte};
			REG_COUNT:   prdata = {22'd0, cfg_q.value_count};
			default:     prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: sv/str_deframer.sv
// ----------------------------------------------------------------------------
// str_deframer
// Telegram state and per-byte logic: header hunt over a five-byte window,
// running CRC-16, range value packing and the closing verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module str_deframer
	import str_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] rx_byte,
	input  wire cfg_t       cfg,
	output res_t            res
);

	// one step of the shifted crc, previous byte joined above the new one
	function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] prev,
		input logic [7:0] b);
		logic [15:0] s;
		s = {c[14:0], 1'b0};
		if (c[15]) begin
			s = s ^ 16'h8005;
		end
		return s ^ {prev, b};
	endfunction

	phase_t      phase_q, phase_d;
	logic [31:0] window_q, window_d;
	logic [2:0]  fill_q, fill_d;
	logic [12:0] left_q, left_d;
	logic [12:0] offset_q, offset_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  prev_q, prev_d;
	logic [7:0]  held_q, held_d;
	logic [9:0]  emitted_q, emitted_d;
	logic [7:0]  crc_lo_q, crc_lo_d;

	logic        hdr_match;
	logic [12:0] hdr_len;
	logic [15:0] hdr_crc;
	logic [15:0] c1, c2, c3, c4;

	// header detection over the four held bytes plus the new one
	assign hdr_match = (fill_q == 3'd4) && (window_q[31:24] == cfg.start_byte)
		&& (window_q[23:16] == cfg.address_byte) && (rx_byte == cfg.command_byte);
	assign hdr_len   = {window_q[4:0], window_q[15:8]};

	// crc over the five header bytes, starting from zero
	assign c1      = crc_step(16'd0, 8'd0, window_q[31:24]);
	assign c2      = crc_step(c1, window_q[31:24], window_q[23:16]);
	assign c3      = crc_step(c2, window_q[23:16], window_q[15:8]);
	assign c4      = crc_step(c3, window_q[15:8], window_q[7:0]);
	assign hdr_crc = crc_step(c4, window_q[7:0], rx_byte);

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_HUNT: begin
				if (hdr_match && hdr_len != 13'd0) begin
					phase_d = (hdr_len == 13'd1) ? PH_CRC_LO : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (left_q == 13'd1) begin
					phase_d = PH_CRC_LO;
				end
			end
			PH_CRC_LO: phase_d = PH_CRC_HI;
			PH_CRC_HI: phase_d = PH_HUNT;
			default:   phase_d = PH_HUNT;
		endcase
	end

	// datapath updates and result
	always_comb begin
		window_d  = window_q;
		fill_d    = fill_q;
		left_d    = left_q;
		offset_d  = offset_q;
		crc_d     = crc_q;
		prev_d    = prev_q;
		held_d    = held_q;
		emitted_d = emitted_q;
		crc_lo_d  = crc_lo_q;
		res       = '0;
		case (phase_q)
			PH_HUNT: begin
				if (hdr_match) begin
					crc_d     = hdr_crc;
					prev_d    = rx_byte;
					emitted_d = '0;
					offset_d  = '0;
					held_d    = '0;
					window_d  = '0;
					fill_d    = '0;
					left_d    = hdr_len - 13'd1;
					if (hdr_len == 13'd0) begin
						left_d    = '0;
						res.valid = 1'b1;
						res.kind  = KIND_BAD_LEN;
						res.frame_end = 1'b1;
					end
				end else begin
					window_d = {window_q[23:0], rx_byte};
					if (fill_q != 3'd4) begin
						fill_d = fill_q + 3'd1;
					end
				end
			end
			PH_PAYLOAD: begin
				crc_d  = crc_step(crc_q, prev_q, rx_byte);
				prev_d = rx_byte;
				if (offset_q >= 13'd2) begin
					if (!offset_q[0]) begin
						held_d = rx_byte;
					end else if (emitted_q < cfg.value_count) begin
						res.valid       = 1'b1;
						res.kind        = KIND_RANGE;
						res.range_value = {rx_byte[4:0], held_q};
						res.value_index = emitted_q;
						emitted_d       = emitted_q + 10'd1;
					end
				end
				offset_d = offset_q + 13'd1;
				left_d   = left_q - 13'd1;
			end
			PH_CRC_LO: begin
				crc_lo_d = rx_byte;
			end
			PH_CRC_HI: begin
				res.valid       = 1'b1;
				res.kind        = ({rx_byte, crc_lo_q} == crc_q) ? KIND_GOOD : KIND_CRC_ERR;
				res.value_index = emitted_q;
				res.frame_end   = 1'b1;
				window_d        = '0;
				fill_d          = '0;
				left_d          = '0;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			window_q  <= '0;
			fill_q    <= '0;
			left_q    <= '0;
			offset_q  <= '0;
			crc_q     <= '0;
			prev_q    <= '0;
			held_q    <= '0;
			emitted_q <= '0;
			crc_lo_q  <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			window_q  <= window_d;
			fill_q    <= fill_d;
			left_q    <= left_d;
			offset_q  <= offset_d;
			crc_q     <= crc_d;
			prev_q    <= prev_d;
			held_q    <= held_d;
			emitted_q <= emitted_d;
			crc_lo_q  <= crc_lo_d;
		end
	end

endmodule

`default_nettype wire

// File: sv/scan_telegram_receiver_core.sv
// ----------------------------------------------------------------------------
// scan_telegram_receiver_core
// Deframes CRC-16 checked scanner telegrams from a byte stream and emits
// range values followed by a frame verdict.
// ----------------------------------------------------------------------------
// Bytes enter an input register, pass through one stage of deframing logic
// (header hunt, one CRC step, value packing) and land in a result register.
// One byte is taken every clock cycle while in_stall is low; a byte yields
// at most one result. The result register is the only point of back-pressure:
// while it holds an untaken result and the byte stage is occupied, in_stall
// is raised. The user must write the registers over the APB port only while
// no telegram byte is in flight; the block does not enforce this.
`default_nettype none

module scan_telegram_receiver_core
	import str_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// byte input
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [7:0]        rx_byte,
	// result output
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [1:0]             result_kind,
	output logic [12:0]            range_value,
	output logic [9:0]             value_index,
	output logic                   frame_end,
	// register port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready
);

	cfg_t       cfg;
	res_t       res;
	res_t       res_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       s1_load;

	// register bank
	str_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// flow control
	assign advance  = !res_q.valid || !out_stall;
	assign s1_load  = !valid_s1 || advance;
	assign in_stall = !s1_load;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	// deframing stage
	str_deframer u_deframer (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (valid_s1 && advance),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (advance) begin
			res_q.valid <= valid_s1 && res.valid;
			if (valid_s1 && res.valid) begin
				res_q.kind        <= res.kind;
				res_q.range_value <= res.range_value;
				res_q.value_index <= res.value_index;
				res_q.frame_end   <= res.frame_end;
			end
		end
	end

	assign out_valid   = res_q.valid;
	assign result_kind = res_q.kind;
	assign range_value = res_q.range_value;
	assign value_index = res_q.value_index;
	assign frame_end   = res_q.frame_end;

`ifndef SYNTHESIS
	// verdicts close a frame, range values never do
	a_end_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_end == (result_kind != KIND_RANGE)))
		else $error("frame_end does not match result kind");

	// verdicts carry no distance
	a_verdict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_end) |-> (range_value == 13'd0))
		else $error("verdict carries a range value");

	// input side stalls only behind a full result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled without a waiting result");

	// a held byte is not lost while the result waits
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> (valid_s1 && $stable(byte_s1)))
		else $error("stalled byte changed");
`endif

endmodule

`default_nettype wire
